// ----- src/ssg_pkg.sv -----
// shared constants, types and functions of the sine sample generator
`default_nettype none
package ssg_pkg;

   localparam int PHASE_BITS    = 32;
   localparam int CORDIC_STAGES = 18;
   localparam int ATAN_ENTRIES  = 24;
   localparam int NSTAGES       = (CORDIC_STAGES < ATAN_ENTRIES) ? CORDIC_STAGES : ATAN_ENTRIES;
   localparam int STAGE_W       = $clog2(NSTAGES);
   localparam int ATAN_IDX_W    = $clog2(ATAN_ENTRIES);

   // datapath word of the rotation, wide enough that x, y and z never wrap
   localparam int CORDIC_W = 34;
   localparam int BIT_W    = $clog2(CORDIC_W);

   localparam int AMP_W    = 16;
   localparam int INDEX_W  = 16;
   localparam int WAVE_W   = 17;
   localparam int ANGLE_W  = 32;
   localparam int CSR_W    = 32;

   localparam int ALIGN_LEFT  = (PHASE_BITS >= 32) ? PHASE_BITS - 32 : 0;
   localparam int ALIGN_RIGHT = (PHASE_BITS >= 32) ? 0 : 32 - PHASE_BITS;

   localparam logic [CORDIC_W-1:0] CORDIC_X0   = CORDIC_W'(652032874);
   localparam logic [INDEX_W-1:0]  COUNT_RESET = INDEX_W'(1000);

   typedef enum logic [1:0] {
      CSR_AMPLITUDE       = 2'd0,
      CSR_PHASE_INCREMENT = 2'd1,
      CSR_PHASE_OFFSET    = 2'd2,
      CSR_SAMPLE_COUNT    = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PHASE,
      ST_ROTATE,
      ST_SCALE,
      ST_OUTPUT
   } state_type;

   typedef struct packed {
      logic [INDEX_W-1:0] index;
      logic               last;
   } sample_info_type;

   typedef struct packed {
      logic [CORDIC_W-1:0] y;
      logic                negate;
   } cordic_result_type;

   function automatic logic [PHASE_BITS-1:0] align_in(input logic [31:0] v);
      logic [63:0] wide;
      wide = {32'd0, v};
      wide = (wide << ALIGN_LEFT) >> ALIGN_RIGHT;
      return wide[PHASE_BITS-1:0];
   endfunction

   function automatic logic [ANGLE_W-1:0] align_out(input logic [PHASE_BITS-1:0] p);
      logic [63:0] wide;
      wide = 64'(p);
      wide = (wide >> ALIGN_LEFT) << ALIGN_RIGHT;
      return wide[ANGLE_W-1:0];
   endfunction

   // atan(2^-k) in units of 2^-32 turn
   function automatic logic [CORDIC_W-1:0] atan_turn(input logic [ATAN_IDX_W-1:0] k);
      logic [CORDIC_W-1:0] a;
      case (k)
         5'd0:    a = CORDIC_W'(536870912);
         5'd1:    a = CORDIC_W'(316933406);
         5'd2:    a = CORDIC_W'(167458907);
         5'd3:    a = CORDIC_W'(85004756);
         5'd4:    a = CORDIC_W'(42667331);
         5'd5:    a = CORDIC_W'(21354465);
         5'd6:    a = CORDIC_W'(10679838);
         5'd7:    a = CORDIC_W'(5340245);
         5'd8:    a = CORDIC_W'(2670163);
         5'd9:    a = CORDIC_W'(1335087);
         5'd10:   a = CORDIC_W'(667544);
         5'd11:   a = CORDIC_W'(333772);
         5'd12:   a = CORDIC_W'(166886);
         5'd13:   a = CORDIC_W'(83443);
         5'd14:   a = CORDIC_W'(41722);
         5'd15:   a = CORDIC_W'(20861);
         5'd16:   a = CORDIC_W'(10430);
         5'd17:   a = CORDIC_W'(5215);
         5'd18:   a = CORDIC_W'(2608);
         5'd19:   a = CORDIC_W'(1304);
         5'd20:   a = CORDIC_W'(652);
         5'd21:   a = CORDIC_W'(326);
         5'd22:   a = CORDIC_W'(163);
         5'd23:   a = CORDIC_W'(81);
         default: a = '0;
      endcase
      return a;
   endfunction

endpackage
`default_nettype wire

// ----- src/sine_sample_generator_unit.sv -----
// top level of the sine sample generator: registers, sequencing and output stage
//
// Each accepted req_ beat yields one rsp_ beat with amplitude*sin(phase) rounded to a signed
// integer, the sample's index in its frame, and a last flag on the final sample of the frame.
// The sine comes from a bit-serial CORDIC that rotates one bit of x, y and z per cycle through
// each stage on 34-bit words. A serial multiply then works through the amplitude one bit at a
// time, and the result is rounded, saturated and handed to the output register. The next req_
// beat is taken once the result has moved into the output register, so no new beat is
// accepted while a sample is in progress. A pending result waiting on rsp_stall does not hold up accepting
// the next beat. Registers are written through the csr_ port, which is always ready; write
// them only while the block is idle.
`default_nettype none
module sine_sample_generator_unit
   import ssg_pkg::*;
(
   input  wire logic                     clock,
   input  wire logic                     reset,

   input  wire logic                     req_valid,
   output logic                          req_stall,
   input  wire logic                     req_restart,

   output logic                          rsp_valid,
   input  wire logic                     rsp_stall,
   output logic signed [WAVE_W-1:0]      rsp_wave_value,
   output logic        [INDEX_W-1:0]     rsp_sample_index,
   output logic                          rsp_last,

   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [1:0]               csr_index,
   input  wire logic [CSR_W-1:0]         csr_data
);

   logic [AMP_W-1:0]   amplitude_ff;
   logic [31:0]        phase_increment_ff;
   logic [31:0]        phase_offset_ff;
   logic [INDEX_W-1:0] sample_count_ff;

   state_type state_ff, state_in;
   logic      accept, cordic_start, scale_start, out_load;

   logic [ANGLE_W-1:0] angle;
   sample_info_type    info;
   logic               cordic_done, scale_done;
   cordic_result_type  cordic_result;
   logic signed [WAVE_W-1:0] wave_value;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic signed [WAVE_W-1:0] wave_ff;
   logic [INDEX_W-1:0]       index_ff;
   logic                     last_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         amplitude_ff       <= '0;
         phase_increment_ff <= '0;
         phase_offset_ff    <= '0;
         sample_count_ff    <= COUNT_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index_type'(csr_index))
            CSR_AMPLITUDE:       amplitude_ff       <= csr_data[AMP_W-1:0];
            CSR_PHASE_INCREMENT: phase_increment_ff <= csr_data[31:0];
            CSR_PHASE_OFFSET:    phase_offset_ff    <= csr_data[31:0];
            CSR_SAMPLE_COUNT:    sample_count_ff    <= csr_data[INDEX_W-1:0];
         endcase
      end
   end

   assign accept = req_valid && !req_stall;

   always_comb begin
      state_in     = state_ff;
      cordic_start = 1'b0;
      scale_start  = 1'b0;
      out_load     = 1'b0;
      req_stall    = state_ff != ST_IDLE;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_PHASE;
            end
         end
         ST_PHASE: begin
            cordic_start = 1'b1;
            state_in     = ST_ROTATE;
         end
         ST_ROTATE: begin
            if (cordic_done) begin
               scale_start = 1'b1;
               state_in    = ST_SCALE;
            end
         end
         ST_SCALE: begin
            if (scale_done) begin
               state_in = ST_OUTPUT;
            end
         end
         ST_OUTPUT: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || !rsp_stall) begin
               out_load = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   ssg_phase u_phase (
      .clock           (clock),
      .reset           (reset),
      .accept          (accept),
      .restart         (req_restart),
      .phase_increment (phase_increment_ff),
      .phase_offset    (phase_offset_ff),
      .sample_count    (sample_count_ff),
      .angle           (angle),
      .info            (info)
   );

   ssg_cordic u_cordic (
      .clock  (clock),
      .reset  (reset),
      .start  (cordic_start),
      .angle  (angle),
      .done   (cordic_done),
      .result (cordic_result)
   );

   ssg_scale u_scale (
      .clock      (clock),
      .reset      (reset),
      .start      (scale_start),
      .operand    (cordic_result),
      .amplitude  (amplitude_ff),
      .done       (scale_done),
      .wave_value (wave_value)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (out_load) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (out_load) begin
         wave_ff  <= wave_value;
         index_ff <= info.index;
         last_ff  <= info.last;
      end
   end

   assign rsp_valid        = rsp_valid_ff;
   assign rsp_wave_value   = wave_ff;
   assign rsp_sample_index = index_ff;
   assign rsp_last         = last_ff;

   a_accept_starts : assert property (@(posedge clock) disable iff (reset)
      accept |=> state_ff == ST_PHASE)
      else $error("accepted beat did not start the phase step");

   a_wave_range : assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_wave_value != -17'sd65536)
      else $error("sample outside the saturated range");

   a_last_index : assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_last) |-> rsp_sample_index == sample_count_ff - INDEX_W'(1))
      else $error("last flag on a sample that does not end the frame");

   a_load_free : assert property (@(posedge clock) disable iff (reset)
      out_load |-> (!rsp_valid || !rsp_stall))
      else $error("output register overwritten while stalled");

endmodule
`default_nettype wire

// ----- src/ssg_phase.sv -----
// phase accumulator and frame index counter
`default_nettype none
module ssg_phase
   import ssg_pkg::*;
(
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   accept,
   input  wire logic                   restart,
   input  wire logic [31:0]            phase_increment,
   input  wire logic [31:0]            phase_offset,
   input  wire logic [INDEX_W-1:0]     sample_count,
   output logic      [ANGLE_W-1:0]     angle,
   output sample_info_type             info
);

   logic [PHASE_BITS-1:0] acc_ff, acc_in;
   logic [INDEX_W-1:0]    index_ff, index_in;
   logic [ANGLE_W-1:0]    angle_ff, angle_in;
   sample_info_type       info_ff, info_in;

   logic [PHASE_BITS-1:0] acc_cur;
   logic [INDEX_W-1:0]    index_cur;
   logic                  is_last;

   always_comb begin
      acc_cur   = restart ? '0 : acc_ff;
      index_cur = restart ? '0 : index_ff;
      is_last   = index_cur == (sample_count - INDEX_W'(1));

      acc_in   = acc_ff;
      index_in = index_ff;
      angle_in = angle_ff;
      info_in  = info_ff;
      if (accept) begin
         angle_in      = align_out(align_in(phase_offset) + acc_cur);
         info_in.index = index_cur;
         info_in.last  = is_last;
         if (is_last) begin
            acc_in   = '0;
            index_in = '0;
         end else begin
            acc_in   = acc_cur + align_in(phase_increment);
            index_in = index_cur + INDEX_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         acc_ff   <= '0;
         index_ff <= '0;
      end else begin
         acc_ff   <= acc_in;
         index_ff <= index_in;
      end
      angle_ff <= angle_in;
      info_ff  <= info_in;
   end

   assign angle = angle_ff;
   assign info  = info_ff;

endmodule
`default_nettype wire

// ----- src/ssg_cordic.sv -----
// bit-serial cordic rotator, one result bit of x, y and z per cycle
`default_nettype none
module ssg_cordic
   import ssg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire logic [ANGLE_W-1:0] angle,
   output logic                    done,
   output cordic_result_type       result
);

   logic [CORDIC_W-1:0] x_ff, x_in, y_ff, y_in, z_ff, z_in;
   logic [CORDIC_W-1:0] xn_ff, xn_in, yn_ff, yn_in, zn_ff, zn_in;
   logic                cx_ff, cx_in, cy_ff, cy_in, cz_ff, cz_in;
   logic [BIT_W-1:0]    bit_ff, bit_in;
   logic [STAGE_W-1:0]  stage_ff, stage_in;
   logic                run_ff, run_in;
   logic                done_ff, done_in;
   logic                negate_ff, negate_in;

   logic [BIT_W:0]      tap_sum;
   logic [BIT_W-1:0]    tap;
   logic [CORDIC_W-1:0] atan_w;
   logic                dir, last_bit, last_stage;
   logic                xs, ys, ab, bx, by, bz, kx, ky, kz, sx, sy, sz;
   logic [ANGLE_W-1:0]  folded;

   always_comb begin
      // arithmetic right shift by the stage number: tap saturates at the sign bit
      tap_sum    = (BIT_W+1)'(bit_ff) + (BIT_W+1)'(stage_ff);
      tap        = (tap_sum > (BIT_W+1)'(CORDIC_W - 1)) ? BIT_W'(CORDIC_W - 1)
                                                        : tap_sum[BIT_W-1:0];
      atan_w     = atan_turn(ATAN_IDX_W'(stage_ff));
      dir        = ~z_ff[CORDIC_W-1];
      last_bit   = bit_ff == BIT_W'(CORDIC_W - 1);
      last_stage = stage_ff == STAGE_W'(NSTAGES - 1);

      xs = x_ff[tap];
      ys = y_ff[tap];
      ab = atan_w[bit_ff];

      // subtraction as add of the inverted bit with carry in of one
      bx = dir ? ~ys : ys;
      by = dir ? xs : ~xs;
      bz = dir ? ~ab : ab;
      kx = (bit_ff == '0) ? dir  : cx_ff;
      ky = (bit_ff == '0) ? ~dir : cy_ff;
      kz = (bit_ff == '0) ? dir  : cz_ff;

      sx = x_ff[bit_ff] ^ bx ^ kx;
      sy = y_ff[bit_ff] ^ by ^ ky;
      sz = z_ff[bit_ff] ^ bz ^ kz;

      folded = angle;
      folded[ANGLE_W-1] = angle[ANGLE_W-1] ^ (angle[ANGLE_W-1] ^ angle[ANGLE_W-2]);

      x_in      = x_ff;
      y_in      = y_ff;
      z_in      = z_ff;
      xn_in     = xn_ff;
      yn_in     = yn_ff;
      zn_in     = zn_ff;
      cx_in     = cx_ff;
      cy_in     = cy_ff;
      cz_in     = cz_ff;
      bit_in    = bit_ff;
      stage_in  = stage_ff;
      run_in    = run_ff;
      done_in   = 1'b0;
      negate_in = negate_ff;

      if (start) begin
         x_in      = CORDIC_X0;
         y_in      = '0;
         z_in      = CORDIC_W'($signed(folded));
         negate_in = angle[ANGLE_W-1] ^ angle[ANGLE_W-2];
         bit_in    = '0;
         stage_in  = '0;
         run_in    = 1'b1;
      end else if (run_ff) begin
         cx_in = (x_ff[bit_ff] & bx) | (x_ff[bit_ff] & kx) | (bx & kx);
         cy_in = (y_ff[bit_ff] & by) | (y_ff[bit_ff] & ky) | (by & ky);
         cz_in = (z_ff[bit_ff] & bz) | (z_ff[bit_ff] & kz) | (bz & kz);
         xn_in = {sx, xn_ff[CORDIC_W-1:1]};
         yn_in = {sy, yn_ff[CORDIC_W-1:1]};
         zn_in = {sz, zn_ff[CORDIC_W-1:1]};
         if (last_bit) begin
            x_in   = xn_in;
            y_in   = yn_in;
            z_in   = zn_in;
            bit_in = '0;
            if (last_stage) begin
               run_in  = 1'b0;
               done_in = 1'b1;
            end else begin
               stage_in = stage_ff + STAGE_W'(1);
            end
         end else begin
            bit_in = bit_ff + BIT_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
      end
      x_ff      <= x_in;
      y_ff      <= y_in;
      z_ff      <= z_in;
      xn_ff     <= xn_in;
      yn_ff     <= yn_in;
      zn_ff     <= zn_in;
      cx_ff     <= cx_in;
      cy_ff     <= cy_in;
      cz_ff     <= cz_in;
      bit_ff    <= bit_in;
      stage_ff  <= stage_in;
      negate_ff <= negate_in;
   end

   assign done          = done_ff;
   assign result.y      = y_ff;
   assign result.negate = negate_ff;

endmodule
`default_nettype wire

// ----- src/ssg_scale.sv -----
// serial amplitude multiply, one amplitude bit per cycle, then round and saturate
`default_nettype none
module ssg_scale
   import ssg_pkg::*;
(
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               start,
   input  wire cordic_result_type  operand,
   input  wire logic [AMP_W-1:0]   amplitude,
   output logic                    done,
   output logic signed [WAVE_W-1:0] wave_value
);

   localparam int ACC_W = AMP_W + CORDIC_W;
   localparam int CNT_W = $clog2(AMP_W);
   localparam int MAG_W = ACC_W - 30;

   logic [ACC_W-1:0]  acc_ff, acc_in, mcand_ff, mcand_in;
   logic [AMP_W-1:0]  amp_ff, amp_in;
   logic [CNT_W-1:0]  cnt_ff, cnt_in;
   logic              run_ff, run_in, fin_ff, fin_in, done_ff, done_in;
   logic              neg_ff, neg_in;
   logic [WAVE_W-1:0] wave_ff, wave_in;

   logic [CORDIC_W-1:0] y_abs;
   logic [ACC_W-1:0]    rounded;
   logic [MAG_W-1:0]    mag;
   logic [AMP_W-1:0]    sat;

   always_comb begin
      y_abs   = operand.y[CORDIC_W-1] ? -operand.y : operand.y;
      rounded = acc_ff + (ACC_W'(1) << 29);
      mag     = rounded[ACC_W-1:30];
      sat     = (mag > MAG_W'(65535)) ? AMP_W'(65535) : mag[AMP_W-1:0];

      acc_in   = acc_ff;
      mcand_in = mcand_ff;
      amp_in   = amp_ff;
      cnt_in   = cnt_ff;
      run_in   = run_ff;
      fin_in   = 1'b0;
      done_in  = 1'b0;
      neg_in   = neg_ff;
      wave_in  = wave_ff;

      if (start) begin
         acc_in   = '0;
         mcand_in = ACC_W'(y_abs);
         amp_in   = amplitude;
         cnt_in   = '0;
         run_in   = 1'b1;
         neg_in   = operand.negate ^ operand.y[CORDIC_W-1];
      end else if (run_ff) begin
         if (amp_ff[0]) begin
            acc_in = acc_ff + mcand_ff;
         end
         mcand_in = mcand_ff << 1;
         amp_in   = amp_ff >> 1;
         cnt_in   = cnt_ff + CNT_W'(1);
         if (cnt_ff == CNT_W'(AMP_W - 1)) begin
            run_in = 1'b0;
            fin_in = 1'b1;
         end
      end else if (fin_ff) begin
         wave_in = neg_ff ? -{1'b0, sat} : {1'b0, sat};
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         fin_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         run_ff  <= run_in;
         fin_ff  <= fin_in;
         done_ff <= done_in;
      end
      acc_ff   <= acc_in;
      mcand_ff <= mcand_in;
      amp_ff   <= amp_in;
      cnt_ff   <= cnt_in;
      neg_ff   <= neg_in;
      wave_ff  <= wave_in;
   end

   assign done       = done_ff;
   assign wave_value = $signed(wave_ff);

endmodule
`default_nettype wire
